FILE: sv/pssd_pkg.sv
// ---------------------------------------------------------------------------
// pssd_pkg
// types and constants for the paletted sprite stream decoder
// ---------------------------------------------------------------------------
package pssd_pkg;

  // largest frame width or height accepted
  localparam int MAX_FRAME_DIM = 1024;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } pssd_in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [10:0]        frame_width;
    logic [10:0]        frame_height;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [2:0]         orientation;
    logic [1:0]         render_mode;
    logic [2:0]         error_code;
  } pssd_out_t;

  typedef enum logic [2:0] {
    PH_HEADER, PH_NCOL, PH_PAL, PH_FTYPE, PH_FHDR, PH_PIX, PH_DONE, PH_ERR
  } pssd_phase_t;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_FHDR  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  localparam logic [2:0] ERR_IDENT   = 3'd1;
  localparam logic [2:0] ERR_VERSION = 3'd2;
  localparam logic [2:0] ERR_NCOL    = 3'd3;
  localparam logic [2:0] ERR_FRAME   = 3'd4;
  localparam logic [2:0] ERR_TRUNC   = 3'd5;

  localparam logic [1:0] MODE_INDEX_ALPHA = 2'd2;
  localparam logic [1:0] MODE_ALPHA_TEST  = 2'd3;

  localparam logic [31:0] IDENT_IDSP = 32'h5053_4449;
  localparam logic [31:0] SPR_VERSION = 32'd2;

  // palette memory write request
  typedef struct packed {
    logic        we;
    logic [7:0]  waddr;
    logic [23:0] wdata;
  } pssd_pal_wr_t;

endpackage

FILE: sv/pssd_palette.sv
// ---------------------------------------------------------------------------
// pssd_palette
// 256 x 24 palette memory with a fill count so each file starts all zero
// ---------------------------------------------------------------------------
module pssd_palette
  import pssd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         clear,
  input  pssd_pal_wr_t wr,
  input  logic         re,
  input  logic [7:0]   raddr,
  output logic [23:0]  rdata
);

  logic [23:0] mem [256];
  logic [8:0]  fill_r;
  logic [23:0] rd_r;
  logic        rhit_r;

  // colours load in index order, so only entries below the fill count are live
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (clear) begin
      fill_r <= '0;
    end else if (wr.we) begin
      fill_r <= fill_r + 9'd1;
    end
  end

  // memory write and registered read; the read holds while the pipe stalls
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr] <= wr.wdata;
    end
    if (re) begin
      rd_r   <= mem[raddr];
      rhit_r <= ({1'b0, raddr} < fill_r);
    end
  end

  assign rdata = rhit_r ? rd_r : 24'd0;

endmodule

FILE: sv/paletted_sprite_stream_decoder_top.sv
// ---------------------------------------------------------------------------
// paletted_sprite_stream_decoder_top
// sprite file byte stream parser with palette lookup to rgba
// ---------------------------------------------------------------------------
// path: a transferred byte's result is registered in stage 1, then in the output
//   register, from which it is offered
// throughput: one byte per cycle back to back; input stalls only while stage 1
//   and the output register both hold results and out_ready is low
// reset: synchronous active low; palette cleared per file by a fill count,
//   no clearing pass
module paletted_sprite_stream_decoder_top
  import pssd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pssd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output pssd_out_t out_data
);

  localparam logic [31:0] MAX_DIM = 32'(MAX_FRAME_DIM);

  pssd_phase_t  phase_r, phase_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [31:0]  word_r, word_nxt;
  logic [2:0]   orient_r, orient_nxt;
  logic [1:0]   mode_r, mode_nxt;
  logic [31:0]  frames_r, frames_nxt;
  logic [16:0]  ncol_r, ncol_nxt;
  logic [10:0]  wid_r, wid_nxt;
  logic [10:0]  hgt_r, hgt_nxt;
  logic [20:0]  pix_r, pix_nxt;
  logic [31:0]  ox_r, ox_nxt;
  logic [31:0]  oy_r, oy_nxt;
  logic [15:0]  rg_r, rg_nxt;

  // stage 1 holds a result waiting for the palette read
  logic         s1_v_r;
  pssd_out_t    s1_r, s1_nxt;
  logic         s1_pix_r;
  logic [7:0]   s1_idx_r;
  logic         gen;
  logic         adv;

  // output register
  logic         ov_r;
  pssd_out_t    od_r;

  pssd_pal_wr_t pal_wr;
  logic         pal_clear;
  logic [23:0]  pal_rd;
  logic         fire;
  logic [7:0]   b;
  logic [31:0]  w;
  logic [5:0]   k;
  logic [21:0]  area;

  pssd_palette u_pal (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (pal_clear),
    .wr    (pal_wr),
    .re    (in_ready),
    .raddr (in_data.data_byte),
    .rdata (pal_rd)
  );

  assign adv      = !ov_r || out_ready;
  assign in_ready = !s1_v_r || adv;
  assign fire     = in_valid && in_ready;
  assign b        = in_data.data_byte;
  assign k        = cnt_r;
  assign w        = word_r | ({24'd0, b} << {k[1:0], 3'b000});
  assign area     = {11'd0, wid_r} * {11'd0, w[10:0]};

  // parser next state
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    word_nxt   = word_r;
    orient_nxt = orient_r;
    mode_nxt   = mode_r;
    frames_nxt = frames_r;
    ncol_nxt   = ncol_r;
    wid_nxt    = wid_r;
    hgt_nxt    = hgt_r;
    pix_nxt    = pix_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    rg_nxt     = rg_r;
    gen        = 1'b0;
    pal_clear  = 1'b0;
    pal_wr     = '0;
    s1_nxt     = '0;
    s1_nxt.orientation = orient_r;
    s1_nxt.render_mode = mode_r;
    if (fire) begin
      if (in_data.end_of_stream) begin
        if (phase_r == PH_DONE) begin
          gen = 1'b1;
          s1_nxt.kind = KIND_DONE;
        end else if (phase_r != PH_ERR) begin
          gen = 1'b1;
          s1_nxt.kind = KIND_ERR;
          s1_nxt.error_code = ERR_TRUNC;
        end
        phase_nxt = PH_HEADER; cnt_nxt = '0; word_nxt = '0;
        orient_nxt = '0; mode_nxt = '0; frames_nxt = '0; ncol_nxt = '0;
        wid_nxt = '0; hgt_nxt = '0; pix_nxt = '0; ox_nxt = '0; oy_nxt = '0;
        pal_clear = 1'b1;
      end else begin
        unique case (phase_r)
          PH_DONE, PH_ERR: begin
          end
          PH_PAL: begin
            // word_r holds colour index, cnt_r the component
            if (cnt_r == 6'd2) begin
              pal_wr.we    = (word_r < 32'd256);
              pal_wr.waddr = word_r[7:0];
              pal_wr.wdata = {rg_r, b};
              cnt_nxt  = '0;
              word_nxt = word_r + 32'd1;
              ncol_nxt = ncol_r - 17'd1;
              if (ncol_r == 17'd1) begin
                phase_nxt = (frames_r == 32'd0) ? PH_DONE : PH_FTYPE;
                word_nxt  = '0;
              end
            end else begin
              if (cnt_r == 6'd0) rg_nxt[15:8] = b;
              else rg_nxt[7:0] = b;
              cnt_nxt = cnt_r + 6'd1;
            end
          end
          PH_PIX: begin
            gen = 1'b1;
            s1_nxt.kind         = KIND_PIXEL;
            s1_nxt.frame_width  = wid_r;
            s1_nxt.frame_height = hgt_r;
            s1_nxt.origin_x     = ox_r;
            s1_nxt.origin_y     = oy_r;
            pix_nxt = pix_r - 21'd1;
            if (pix_r == 21'd1) begin
              frames_nxt = frames_r - 32'd1;
              phase_nxt  = (frames_r == 32'd1) ? PH_DONE : PH_FTYPE;
              cnt_nxt = '0; word_nxt = '0;
            end
          end
          PH_NCOL: begin
            word_nxt = w;
            cnt_nxt  = k + 6'd1;
            if (k != 6'd0) begin
              if (w[15]) begin
                gen = 1'b1; s1_nxt.kind = KIND_ERR; s1_nxt.error_code = ERR_NCOL;
                phase_nxt = PH_ERR;
              end else begin
                ncol_nxt = {1'b0, w[15:0]};
                cnt_nxt = '0; word_nxt = '0;
                if (w[15:0] == 16'd0)
                  phase_nxt = (frames_r == 32'd0) ? PH_DONE : PH_FTYPE;
                else phase_nxt = PH_PAL;
              end
            end
          end
          PH_HEADER, PH_FTYPE, PH_FHDR: begin
            word_nxt = w;
            cnt_nxt  = k + 6'd1;
            if (k[1:0] == 2'd3) begin
              word_nxt = '0;
              if (phase_r == PH_HEADER) begin
                if (k[5:2] == 4'd0 && w != IDENT_IDSP) begin
                  gen = 1'b1; s1_nxt.kind = KIND_ERR; s1_nxt.error_code = ERR_IDENT;
                  phase_nxt = PH_ERR;
                end else if (k[5:2] == 4'd1 && w != SPR_VERSION) begin
                  gen = 1'b1; s1_nxt.kind = KIND_ERR; s1_nxt.error_code = ERR_VERSION;
                  phase_nxt = PH_ERR;
                end else begin
                  if (k[5:2] == 4'd2) orient_nxt = (w <= 32'd4) ? w[2:0] : 3'd0;
                  if (k[5:2] == 4'd3) mode_nxt = (w <= 32'd3) ? w[1:0] : 2'd0;
                  if (k[5:2] == 4'd7) frames_nxt = w[31] ? 32'd0 : w;
                  if (k >= 6'd39) begin
                    phase_nxt = PH_NCOL; cnt_nxt = '0;
                  end
                end
              end else if (phase_r == PH_FTYPE) begin
                if (w != 32'd0) begin
                  gen = 1'b1; s1_nxt.kind = KIND_ERR; s1_nxt.error_code = ERR_FRAME;
                  phase_nxt = PH_ERR;
                end else begin
                  phase_nxt = PH_FHDR; cnt_nxt = '0;
                end
              end else begin
                unique case (k[3:2])
                  2'd0: ox_nxt = w;
                  2'd1: oy_nxt = w;
                  2'd2: begin
                    if (w > MAX_DIM) begin
                      gen = 1'b1; s1_nxt.kind = KIND_ERR; s1_nxt.error_code = ERR_FRAME;
                      phase_nxt = PH_ERR;
                    end else wid_nxt = w[10:0];
                  end
                  default: begin
                    if (w > MAX_DIM) begin
                      gen = 1'b1; s1_nxt.kind = KIND_ERR; s1_nxt.error_code = ERR_FRAME;
                      phase_nxt = PH_ERR;
                    end else begin
                      hgt_nxt = w[10:0];
                      gen = 1'b1;
                      s1_nxt.kind         = KIND_FHDR;
                      s1_nxt.frame_width  = wid_r;
                      s1_nxt.frame_height = w[10:0];
                      s1_nxt.origin_x     = ox_r;
                      s1_nxt.origin_y     = oy_r;
                      pix_nxt = area[20:0];
                      cnt_nxt = '0;
                      if (area == 22'd0) begin
                        frames_nxt = frames_r - 32'd1;
                        phase_nxt  = (frames_r == 32'd1) ? PH_DONE : PH_FTYPE;
                      end else phase_nxt = PH_PIX;
                    end
                  end
                endcase
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER; cnt_r <= '0; word_r <= '0; orient_r <= '0;
      mode_r <= '0; frames_r <= '0; ncol_r <= '0; wid_r <= '0; hgt_r <= '0;
      pix_r <= '0; ox_r <= '0; oy_r <= '0; rg_r <= '0;
    end else begin
      phase_r <= phase_nxt; cnt_r <= cnt_nxt; word_r <= word_nxt;
      orient_r <= orient_nxt; mode_r <= mode_nxt; frames_r <= frames_nxt;
      ncol_r <= ncol_nxt; wid_r <= wid_nxt; hgt_r <= hgt_nxt; pix_r <= pix_nxt;
      ox_r <= ox_nxt; oy_r <= oy_nxt; rg_r <= rg_nxt;
    end
  end

  // pixel colour from the palette read
  pssd_out_t s1_fin;
  always_comb begin
    s1_fin = s1_r;
    if (s1_pix_r) begin
      s1_fin.red   = pal_rd[23:16];
      s1_fin.green = pal_rd[15:8];
      s1_fin.blue  = pal_rd[7:0];
      s1_fin.alpha = 8'd255;
      if (s1_r.render_mode == MODE_INDEX_ALPHA) begin
        s1_fin.red = 8'd255; s1_fin.green = 8'd255; s1_fin.blue = 8'd255;
        s1_fin.alpha = s1_idx_r;
      end else if (s1_r.render_mode == MODE_ALPHA_TEST) begin
        s1_fin.alpha = (s1_idx_r == 8'd255) ? 8'd0 : 8'd255;
      end
    end
  end

  // stage 1 and output register; stage 1 loads with the palette read, so both hold together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (adv) begin
        ov_r <= s1_v_r;
        if (s1_v_r) od_r <= s1_fin;
      end
      if (in_ready) s1_v_r <= fire && gen;
    end
    if (in_ready) begin
      s1_r     <= s1_nxt;
      s1_pix_r <= fire && gen && (s1_nxt.kind == KIND_PIXEL);
      s1_idx_r <= b;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

`ifndef SYNTH
  // a transfer only when stage 1 can move on
  a_in_ok: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (!s1_v_r || adv)) else $error("input taken while stalled");
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("output changed while stalled");
  // a pixel result only from pixel phase
  a_pix: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && gen && s1_nxt.kind == KIND_PIXEL) |-> (phase_r == PH_PIX))
    else $error("pixel outside pixel phase");
`endif

endmodule
